FILE: design/mnie_pkg.sv
// Shared types and constants for the incident edge min/max block.
// Used by mnie_wrap, mnie_sqacc and the top level in this folder; depends on nothing.
package mnie_pkg;

    localparam int ID_W   = 10;
    localparam int CRD_W  = 16;
    localparam int SQ_W   = 34;
    localparam int KIND_W = 2;
    localparam int NPE_W  = 3;
    localparam int DIM_W  = 2;
    localparam int CFG_W  = 3;
    localparam int CFG_AW = 1;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 72;

    localparam logic [SQ_W-1:0] SQ_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_POS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_NPE  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_DIMS = 1'b1;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
    } t_sq_ctl;

endpackage

FILE: design/mnie_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mnie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/mnie_wrap.sv
// Two-stage node id wrap: id modulo NODE_COUNT by reciprocal multiply and one correction.
// Depends on mnie_pkg.
module mnie_wrap #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                          i_clk,
    input  logic [mnie_pkg::ID_W-1:0]     i_id,
    output logic [$clog2(NODE_COUNT)-1:0] o_idx
);
    import mnie_pkg::*;

    localparam int AW    = $clog2(NODE_COUNT);
    localparam int SPAN  = 1 << ID_W;
    localparam int RECIP = SPAN / NODE_COUNT;
    localparam int RW    = ID_W;
    localparam int NCW   = $clog2(NODE_COUNT) + 1;
    localparam int PW    = RW + NCW;

    logic [ID_W+RW-1:0] prod;
    logic [RW-1:0]      r_q;
    logic [ID_W-1:0]    r_id;
    logic [PW-1:0]      qn;
    logic [ID_W-1:0]    rem;
    logic [NCW-1:0]     remw;
    logic [ID_W-1:0]    r_rem;

    always_comb begin
        prod = (ID_W+RW)'(i_id) * (ID_W+RW)'(RECIP);
        qn   = PW'(r_q) * PW'(NODE_COUNT);
        rem  = r_id - ID_W'(qn);
        remw = NCW'(rem);
    end

    always_ff @(posedge i_clk) begin
        r_q  <= prod[ID_W +: RW];
        r_id <= i_id;
        if (remw >= NCW'(NODE_COUNT)) begin
            r_rem <= ID_W'(remw - NCW'(NODE_COUNT));
        end else begin
            r_rem <= rem;
        end
    end

    assign o_idx = AW'(r_rem);
endmodule

FILE: design/mnie_sqacc.sv
// Shared square-and-accumulate unit: one coordinate difference squared per cycle,
// summed and saturated to the squared length width. Depends on mnie_pkg.
module mnie_sqacc #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  mnie_pkg::t_sq_ctl            i_ctl,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    output logic [mnie_pkg::SQ_W-1:0]    o_len
);
    import mnie_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int PRW  = 2 * DW;
    localparam int SUMW = (2 * COORD_BITS + 4 > SQ_W) ? 2 * COORD_BITS + 4 : SQ_W;

    logic signed [DW-1:0]  diff;
    logic signed [PRW-1:0] sq;
    logic [PRW-1:0]        r_prod;
    logic [SUMW-1:0]       r_sum;

    always_comb begin
        diff = DW'(i_a) - DW'(i_b);
        sq   = diff * diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= unsigned'(sq);
        end
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + SUMW'(r_prod);
        end
    end

    assign o_len = (r_sum > SUMW'(SQ_MAX)) ? SQ_MAX : r_sum[SQ_W-1:0];
endmodule

FILE: design/mesh_node_incident_edge_min_max.sv
// Top level: per-node min/max of incident squared edge lengths, with sequencer.
// Items are handled one at a time, set by the shared square unit and table port.
// Reset: clears control, then sweeps the min/max table with s_axis_tready low.
// Depends on mnie_pkg, mnie_ram, mnie_wrap, mnie_sqacc.
module mesh_node_incident_edge_min_max #(
    parameter int NODE_COUNT = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_a, node_b, node_c, node_d, coord_x, coord_y, coord_z
    input  logic [mnie_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [mnie_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // min_sq_len, max_sq_len, zero pad
    output logic [mnie_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // read_valid
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [mnie_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [mnie_pkg::CFG_W-1:0]       i_cfg_data
);
    import mnie_pkg::*;

    localparam int AW  = $clog2(NODE_COUNT);
    localparam int CB  = COORD_BITS;
    localparam int PW  = 3 * CB;
    localparam int TW  = 2 * SQ_W;
    localparam int EXW = (CB > CRD_W) ? CB : CRD_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_W1   = 4'd2;
    localparam logic [3:0] S_W2   = 4'd3;
    localparam logic [3:0] S_DISP = 4'd4;
    localparam logic [3:0] S_RDW  = 4'd5;
    localparam logic [3:0] S_PA   = 4'd6;
    localparam logic [3:0] S_PB   = 4'd7;
    localparam logic [3:0] S_PC   = 4'd8;
    localparam logic [3:0] S_SQ   = 4'd9;
    localparam logic [3:0] S_UA   = 4'd10;
    localparam logic [3:0] S_UB   = 4'd11;
    localparam logic [3:0] S_UC   = 4'd12;
    localparam logic [3:0] S_UD   = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_e, n_e;
    logic [1:0]        r_k, n_k;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_boot, n_boot;
    logic [NPE_W-1:0]  r_npe_cfg;
    logic [DIM_W-1:0]  r_dim_cfg;
    logic              r_ovalid;

    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_id [4];
    logic [CRD_W-1:0]  r_crd [3];
    logic [PW-1:0]     r_pa;
    logic [SQ_W-1:0]   r_res_min, r_res_max;
    logic              r_res_rd;
    logic [SQ_W-1:0]   r_omin, r_omax;
    logic              r_ord;

    logic [AW-1:0]     w_idx [4];
    logic [NPE_W-1:0]  npe;
    logic [DIM_W-1:0]  dims;
    logic              last_in_loop, last_edge;
    logic [1:0]        q_sel;
    logic [AW-1:0]     p_idx, q_idx;
    logic [CB-1:0]     crd_int [3];
    logic [EXW-1:0]    crd_ext [3];

    logic              pos_we;
    logic [PW-1:0]     pos_wdata, pos_rdata;
    logic [AW-1:0]     pos_raddr;
    logic              tab_we;
    logic [AW-1:0]     tab_waddr, tab_raddr;
    logic [TW-1:0]     tab_wdata, tab_rdata;
    logic [SQ_W-1:0]   old_min, old_max, new_min, new_max, len;

    t_sq_ctl           sq_ctl;
    logic signed [CB-1:0] sq_a, sq_b;

    logic              out_load;

    for (genvar g = 0; g < 4; g++) begin : g_wrap
        mnie_wrap #(.NODE_COUNT(NODE_COUNT)) u_wrap (
            .i_clk (i_clk),
            .i_id  (r_id[g]),
            .o_idx (w_idx[g])
        );
    end

    for (genvar g = 0; g < 3; g++) begin : g_crd
        assign crd_ext[g] = EXW'(r_crd[g]);
        assign crd_int[g] = crd_ext[g][CB-1:0];
    end

    always_comb begin
        if (r_npe_cfg < NPE_W'(2)) begin
            npe = NPE_W'(2);
        end else if (r_npe_cfg > NPE_W'(4)) begin
            npe = NPE_W'(4);
        end else begin
            npe = r_npe_cfg;
        end
        dims = (r_dim_cfg < DIM_W'(3)) ? DIM_W'(2) : DIM_W'(3);

        last_in_loop = ({1'b0, r_e} == npe - NPE_W'(1));
        last_edge    = (npe == NPE_W'(2)) || last_in_loop;
        q_sel        = last_in_loop ? 2'd0 : r_e + 2'd1;
        p_idx        = w_idx[r_e];
        q_idx        = w_idx[q_sel];

        old_min = tab_rdata[SQ_W-1:0];
        old_max = tab_rdata[TW-1:SQ_W];
        new_min = (len < old_min) ? len : old_min;
        new_max = (len > old_max) ? len : old_max;

        pos_we    = (r_state == S_DISP) && (r_kind == KIND_POS);
        pos_wdata = {crd_int[2], crd_int[1], crd_int[0]};
        pos_raddr = (r_state == S_PA) ? p_idx : q_idx;

        tab_we = (r_state == S_CLR) || (r_state == S_UB) || (r_state == S_UD);
        if (r_state == S_CLR) begin
            tab_waddr = r_clr_addr;
            tab_wdata = {{SQ_W{1'b0}}, SQ_MAX};
        end else begin
            tab_waddr = (r_state == S_UB) ? p_idx : q_idx;
            tab_wdata = {new_max, new_min};
        end
        if ((r_state == S_UA) || (r_state == S_UB)) begin
            tab_raddr = p_idx;
        end else if ((r_state == S_UC) || (r_state == S_UD)) begin
            tab_raddr = q_idx;
        end else begin
            tab_raddr = w_idx[0];
        end

        sq_ctl.clr = (r_state == S_PC);
        sq_ctl.mul = (r_state == S_SQ) && (r_k < dims);
        sq_ctl.acc = (r_state == S_SQ) && (r_k != 2'd0);
        case (r_k)
            2'd0: begin
                sq_a = r_pa[0 +: CB];
                sq_b = pos_rdata[0 +: CB];
            end
            2'd1: begin
                sq_a = r_pa[CB +: CB];
                sq_b = pos_rdata[CB +: CB];
            end
            default: begin
                sq_a = r_pa[2*CB +: CB];
                sq_b = pos_rdata[2*CB +: CB];
            end
        endcase
    end

    mnie_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (w_idx[0]),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    mnie_ram #(.WIDTH(TW), .DEPTH(NODE_COUNT)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    mnie_sqacc #(.COORD_BITS(CB)) u_sqacc (
        .i_clk (i_clk),
        .i_ctl (sq_ctl),
        .i_a   (sq_a),
        .i_b   (sq_b),
        .o_len (len)
    );

    assign out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state    = r_state;
        n_e        = r_e;
        n_k        = r_k;
        n_clr_addr = r_clr_addr;
        n_boot     = r_boot;
        unique case (r_state)
            S_CLR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_boot     = 1'b0;
                    n_state    = r_boot ? S_IDLE : S_OUT;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_W1;
                end
            end
            S_W1: n_state = S_W2;
            S_W2: n_state = S_DISP;
            S_DISP: begin
                unique case (r_kind)
                    KIND_POS:  n_state = S_OUT;
                    KIND_ELEM: begin
                        n_e     = 2'd0;
                        n_state = S_PA;
                    end
                    KIND_READ: n_state = S_RDW;
                    default:   n_state = S_CLR;
                endcase
            end
            S_RDW: n_state = S_OUT;
            S_PA:  n_state = S_PB;
            S_PB:  n_state = S_PC;
            S_PC: begin
                n_k     = 2'd0;
                n_state = S_SQ;
            end
            S_SQ: begin
                if (r_k == dims) begin
                    n_state = S_UA;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_UA: n_state = S_UB;
            S_UB: n_state = S_UC;
            S_UC: n_state = S_UD;
            S_UD: begin
                if (last_edge) begin
                    n_state = S_OUT;
                end else begin
                    n_e     = r_e + 2'd1;
                    n_state = S_PA;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_e        <= '0;
            r_k        <= '0;
            r_clr_addr <= '0;
            r_boot     <= 1'b1;
            r_npe_cfg  <= NPE_W'(3);
            r_dim_cfg  <= DIM_W'(3);
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_e        <= n_e;
            r_k        <= n_k;
            r_clr_addr <= n_clr_addr;
            r_boot     <= n_boot;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NPE:  r_npe_cfg <= i_cfg_data[NPE_W-1:0];
                    CFG_DIMS: r_dim_cfg <= i_cfg_data[DIM_W-1:0];
                    default:  r_dim_cfg <= r_dim_cfg;
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && s_axis_tvalid) begin
            r_kind   <= s_axis_tuser;
            r_id[0]  <= s_axis_tdata[0*ID_W +: ID_W];
            r_id[1]  <= s_axis_tdata[1*ID_W +: ID_W];
            r_id[2]  <= s_axis_tdata[2*ID_W +: ID_W];
            r_id[3]  <= s_axis_tdata[3*ID_W +: ID_W];
            r_crd[0] <= s_axis_tdata[4*ID_W +: CRD_W];
            r_crd[1] <= s_axis_tdata[4*ID_W + CRD_W +: CRD_W];
            r_crd[2] <= s_axis_tdata[4*ID_W + 2*CRD_W +: CRD_W];
        end
        if (r_state == S_PB) begin
            r_pa <= pos_rdata;
        end
        if (r_state == S_DISP) begin
            r_res_min <= '0;
            r_res_max <= '0;
            r_res_rd  <= 1'b0;
        end else if (r_state == S_RDW) begin
            r_res_min <= tab_rdata[SQ_W-1:0];
            r_res_max <= tab_rdata[TW-1:SQ_W];
            r_res_rd  <= 1'b1;
        end
        if (out_load) begin
            r_omin <= r_res_min;
            r_omax <= r_res_max;
            r_ord  <= r_res_rd;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(M_TDATA_W - TW){1'b0}}, r_omax, r_omin};
    assign m_axis_tuser  = r_ord;
endmodule

FILE: tb/sv/tb_mesh_node_incident_edge_min_max.sv
// Self-checking testbench for mesh_node_incident_edge_min_max: random and directed items on
// the stream ports, a scoreboard class that predicts per-node incident edge length min/max.
// Depends on mnie_pkg and the block's top level.
`timescale 1ns / 100ps

module tb_mesh_node_incident_edge_min_max;
    import mnie_pkg::*;

    localparam int NODES      = 1024;
    localparam int PHASE_LEN  = 50;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ID_W-1:0]         a;
        logic [ID_W-1:0]         b;
        logic [ID_W-1:0]         c;
        logic [ID_W-1:0]         d;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } t_mesh_item;

    typedef struct packed {
        logic [SQ_W-1:0] min_len;
        logic [SQ_W-1:0] max_len;
        logic            rd;
    } t_len_pair;

    class edge_len_scoreboard;
        logic signed [CRD_W-1:0] pos [NODES][3];
        logic [SQ_W-1:0]         min_len [NODES];
        logic [SQ_W-1:0]         max_len [NODES];
        logic [NPE_W-1:0]        npe_reg;
        logic [DIM_W-1:0]        dim_reg;
        t_len_pair               pending_q [$];
        int unsigned             mismatches;

        function new();
            foreach (pos[i]) begin
                pos[i][0] = '0;
                pos[i][1] = '0;
                pos[i][2] = '0;
            end
            clear_tables();
            npe_reg    = 3'd3;
            dim_reg    = 2'd3;
            mismatches = 0;
        endfunction

        function void clear_tables();
            foreach (min_len[i]) begin
                min_len[i] = SQ_MAX;
                max_len[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] data);
            if (addr == CFG_NPE) npe_reg = data[NPE_W-1:0];
            else if (addr == CFG_DIMS) dim_reg = data[DIM_W-1:0];
        endfunction

        function int nodes_used();
            if (npe_reg < 2) return 2;
            if (npe_reg > 4) return 4;
            return int'(npe_reg);
        endfunction

        function logic [SQ_W-1:0] edge_sq_len(int p, int q);
            longint sum;
            longint dlt;
            int     nd;
            sum = 0;
            nd  = (dim_reg < 2) ? 2 : int'(dim_reg);
            for (int k = 0; k < nd; k++) begin
                dlt = longint'(pos[p][k]) - longint'(pos[q][k]);
                sum += dlt * dlt;
            end
            if (sum > longint'(SQ_MAX)) return SQ_MAX;
            return sum[SQ_W-1:0];
        endfunction

        function void touch(int n, logic [SQ_W-1:0] len);
            if (len < min_len[n]) min_len[n] = len;
            if (len > max_len[n]) max_len[n] = len;
        endfunction

        function void apply_edge(int p, int q);
            logic [SQ_W-1:0] len;
            len = edge_sq_len(p, q);
            touch(p, len);
            touch(q, len);
        endfunction

        function void note_item(t_mesh_item it);
            int        ids [4];
            int        n;
            t_len_pair res;
            ids[0] = int'(it.a);
            ids[1] = int'(it.b);
            ids[2] = int'(it.c);
            ids[3] = int'(it.d);
            n      = nodes_used();
            res    = '0;
            case (it.kind)
                KIND_POS: begin
                    pos[ids[0]][0] = it.x;
                    pos[ids[0]][1] = it.y;
                    pos[ids[0]][2] = it.z;
                end
                KIND_ELEM: begin
                    if (n == 2) apply_edge(ids[0], ids[1]);
                    else for (int e = 0; e < n; e++) apply_edge(ids[e], ids[(e + 1) % n]);
                end
                KIND_READ: begin
                    res.min_len = min_len[ids[0]];
                    res.max_len = max_len[ids[0]];
                    res.rd      = 1'b1;
                end
                default: clear_tables();
            endcase
            pending_q.insert(pending_q.size(), res);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void check_result(t_len_pair got);
            t_len_pair exp_r;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result min=%0d max=%0d rd=%0b",
                                 got.min_len, got.max_len, got.rd));
                return;
            end
            exp_r = pending_q[0];
            pending_q.delete(0);
            if (got.min_len !== exp_r.min_len)
                report($sformatf("min_sq_len exp %0d got %0d", exp_r.min_len, got.min_len));
            if (got.max_len !== exp_r.max_len)
                report($sformatf("max_sq_len exp %0d got %0d", exp_r.max_len, got.max_len));
            if (got.rd !== exp_r.rd)
                report($sformatf("read_valid exp %0b got %0b", exp_r.rd, got.rd));
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_data;

    edge_len_scoreboard sb;
    int                 placed_nodes [$];
    bit                 placed [NODES];
    bit                 quiet;
    bit                 rx_hold_req;

    mesh_node_incident_edge_min_max DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic signed [CRD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            default: return CRD_W'($urandom);
        endcase
    endfunction

    function automatic int pick_placed();
        return placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
    endfunction

    function automatic t_mesh_item pos_item(int n, logic signed [CRD_W-1:0] x,
                                            logic signed [CRD_W-1:0] y,
                                            logic signed [CRD_W-1:0] z);
        t_mesh_item it;
        it      = '0;
        it.kind = KIND_POS;
        it.a    = ID_W'(n);
        it.b    = ID_W'($urandom);
        it.c    = ID_W'($urandom);
        it.d    = ID_W'($urandom);
        it.x    = x;
        it.y    = y;
        it.z    = z;
        if (!placed[n]) begin
            placed[n] = 1'b1;
            placed_nodes.insert(placed_nodes.size(), n);
        end
        return it;
    endfunction

    function automatic t_mesh_item elem_item(int a, int b, int c, int d);
        t_mesh_item it;
        it      = '0;
        it.kind = KIND_ELEM;
        it.a    = ID_W'(a);
        it.b    = ID_W'(b);
        it.c    = ID_W'(c);
        it.d    = ID_W'(d);
        it.x    = CRD_W'($urandom);
        it.y    = CRD_W'($urandom);
        it.z    = CRD_W'($urandom);
        return it;
    endfunction

    function automatic t_mesh_item read_item(int n);
        t_mesh_item it;
        it      = elem_item(n, $urandom, $urandom, $urandom);
        it.kind = KIND_READ;
        return it;
    endfunction

    function automatic t_mesh_item clear_item();
        t_mesh_item it;
        it      = elem_item($urandom, $urandom, $urandom, $urandom);
        it.kind = KIND_CLEAR;
        return it;
    endfunction

    function automatic t_mesh_item random_item();
        int ids [4];
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return clear_item();
        if (r < 27) return pos_item($urandom_range(0, NODES - 1), rand_coord(), rand_coord(),
                                    rand_coord());
        if (r < 65) begin
            n = sb.nodes_used();
            for (int k = 0; k < 4; k++)
                ids[k] = (k < n) ? pick_placed() : int'($urandom_range(0, NODES - 1));
            if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(1, n - 1);
                ids[r] = ids[r - 1];
            end
            return elem_item(ids[0], ids[1], ids[2], ids[3]);
        end
        if ($urandom_range(0, 9) < 7) return read_item(pick_placed());
        return read_item($urandom_range(0, NODES - 1));
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_mesh_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.z, it.y, it.x, it.d, it.c, it.b, it.a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_config(logic [CFG_W-1:0] npe_val, logic [CFG_W-1:0] dim_val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_NPE;
        i_cfg_data <= npe_val;
        @(posedge i_clk);
        sb.set_reg(CFG_NPE, npe_val);
        @(negedge i_clk);
        i_cfg_addr <= CFG_DIMS;
        i_cfg_data <= dim_val;
        @(posedge i_clk);
        sb.set_reg(CFG_DIMS, dim_val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : result_sink
        int        gap;
        t_len_pair got;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                gap         = HOLD_LEN;
                rx_hold_req = 1'b0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.min_len = m_axis_tdata[SQ_W-1:0];
            got.max_len = m_axis_tdata[2*SQ_W-1:SQ_W];
            got.rd      = m_axis_tuser;
            sb.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
            else idle++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] npe_set [8];
        logic [CFG_W-1:0] dim_set [8];
        npe_set = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd5, 3'd3, 3'd1, 3'd4};
        dim_set = '{3'd2, 3'd3, 3'd6, 3'd1, 3'd3, 3'd0, 3'd7, 3'd2};
        sb            = new();
        quiet         = 1'b0;
        rx_hold_req   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(pos_item(0, -16'sd32768, -16'sd32768, -16'sd32768));
        send_item(pos_item(NODES - 1, 16'sd32767, 16'sd32767, 16'sd32767));
        send_item(pos_item(1, 16'sd0, 16'sd0, 16'sd0));
        send_item(pos_item(2, 16'sd32767, -16'sd32768, 16'sd5));
        send_item(read_item(0));
        send_item(elem_item(0, NODES - 1, 1, 0));
        send_item(elem_item(1, 1, 2, NODES - 1));
        send_item(read_item(0));
        send_item(read_item(NODES - 1));
        send_item(read_item(1));
        send_item(read_item(2));
        send_item(clear_item());
        send_item(read_item(0));
        send_item(elem_item(0, NODES - 1, 2, 1));
        send_item(read_item(NODES - 1));
        send_item(read_item(2));
        send_item(read_item(512));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_config(npe_set[ph], dim_set[ph]);
            quiet = (ph == 2) || (ph == 4);
            if (ph == 4) rx_hold_req = 1'b1;
            for (int i = 0; i < PHASE_LEN; i++) send_item(random_item());
            drain();
        end
        quiet = 1'b0;

        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mnie_pkg.sv
design/mnie_ram.sv
design/mnie_wrap.sv
design/mnie_sqacc.sv
design/mesh_node_incident_edge_min_max.sv
tb/sv/tb_mesh_node_incident_edge_min_max.sv
